// ===== rtl/double_ended_queue_with_erase_top_assert.svh =====
// Assertion macros used by the deque top level.
`ifndef DOUBLE_ENDED_QUEUE_WITH_ERASE_TOP_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_WITH_ERASE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define DQE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("deque assertion failed");

`define DQE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("deque assertion failed");

`else

`define DQE_ASSERT_NOW(lbl, ante, cons)

`define DQE_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/dqe_pkg.sv =====
// Types and constants shared by the deque modules.
package dqe_pkg;

  localparam int DATA_W = 32;
  localparam int OCC_W  = 5;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_END   = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_END    = 3'd3,
    OP_COUNT      = 3'd4,
    OP_ERASE      = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP_WAIT,
    S_SCAN,
    S_FRONT_RD,
    S_END_RD,
    S_DONE
  } state_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] answer;
    status_e                  status;
    logic [OCC_W-1:0]         occupancy;
    logic signed [DATA_W-1:0] front;
    logic signed [DATA_W-1:0] back;
  } res_t;

endpackage

// ===== rtl/dqe_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module dqe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/dqe_ctrl.sv =====
// Sequencer for the deque: ring pointers, operation decode and the entry scan.
module dqe_ctrl #(
  parameter int DEPTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [2:0]                        operation_i,
  input  logic signed [dqe_pkg::DATA_W-1:0] item_value_i,
  input  logic                              out_free_i,
  output logic                              res_valid_o,
  output dqe_pkg::res_t                     res_o
);

  import dqe_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW:0]   DEPTH_X = (CW+1)'(DEPTH);
  localparam logic [CW-1:0] FULL_C  = CW'(DEPTH);
  localparam logic [IW-1:0] LAST_C  = IW'(DEPTH - 1);

  state_e              state_q, state_d;
  logic [IW-1:0]       front_q, front_d;
  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       idx_q, idx_d;
  logic [CW-1:0]       kept_q, kept_d;
  logic                pend_q, pend_d;
  op_e                 op_q, op_d;
  logic [DATA_W-1:0]   val_q, val_d;
  logic [DATA_W-1:0]   answer_q, answer_d;
  status_e             status_q, status_d;
  logic [DATA_W-1:0]   front_val_q, front_val_d;

  logic                mem_we, mem_re;
  logic [IW-1:0]       mem_waddr, mem_raddr;
  logic [DATA_W-1:0]   mem_wdata, rd_data;

  logic                full, empty, scan_issue, scan_done;
  logic [IW-1:0]       front_dec, front_inc, end_slot;

  // Physical slot of a position counted from the given front index.
  function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] base,
                                            input logic [CW-1:0] pos);
    logic [CW:0] sum;
    sum = {{(CW+1-IW){1'b0}}, base} + {1'b0, pos};
    if (sum >= DEPTH_X) begin
      sum = sum - DEPTH_X;
    end
    return sum[IW-1:0];
  endfunction

  assign full       = (count_q == FULL_C);
  assign empty      = (count_q == '0);
  assign front_dec  = (front_q == '0) ? LAST_C : front_q - IW'(1);
  assign front_inc  = (front_q == LAST_C) ? '0 : front_q + IW'(1);
  assign end_slot   = slot_of(front_q, empty ? '0 : count_q - CW'(1));
  assign scan_issue = (idx_q < count_q);
  assign scan_done  = !scan_issue && !pend_q;

  dqe_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(rd_data)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        case (op_q)
          OP_POP_FRONT, OP_POP_END: state_d = empty ? S_FRONT_RD : S_POP_WAIT;
          OP_COUNT, OP_ERASE:       state_d = S_SCAN;
          default:                  state_d = S_FRONT_RD;
        endcase
      end
      S_POP_WAIT: state_d = S_FRONT_RD;
      S_SCAN: begin
        if (scan_done) begin
          state_d = S_FRONT_RD;
        end
      end
      S_FRONT_RD: state_d = S_END_RD;
      S_END_RD:   state_d = S_DONE;
      S_DONE: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    front_d     = front_q;
    count_d     = count_q;
    idx_d       = idx_q;
    kept_d      = kept_q;
    pend_d      = 1'b0;
    op_d        = op_q;
    val_d       = val_q;
    answer_d    = answer_q;
    status_d    = status_q;
    front_val_d = front_val_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = val_q;
    mem_re      = 1'b0;
    mem_raddr   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d  = op_e'(operation_i);
          val_d = item_value_i;
        end
      end
      S_EXEC: begin
        answer_d = '0;
        status_d = ST_OK;
        idx_d    = '0;
        kept_d   = '0;
        case (op_q)
          OP_PUSH_FRONT: begin
            if (full) begin
              status_d = ST_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = front_dec;
              front_d   = front_dec;
              count_d   = count_q + CW'(1);
            end
          end
          OP_PUSH_END: begin
            if (full) begin
              status_d = ST_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = slot_of(front_q, count_q);
              count_d   = count_q + CW'(1);
            end
          end
          OP_POP_FRONT: begin
            if (empty) begin
              status_d = ST_EMPTY;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = front_q;
              front_d   = front_inc;
              count_d   = count_q - CW'(1);
            end
          end
          OP_POP_END: begin
            if (empty) begin
              status_d = ST_EMPTY;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = end_slot;
              count_d   = count_q - CW'(1);
            end
          end
          default: ;
        endcase
      end
      S_POP_WAIT: answer_d = rd_data;
      S_SCAN: begin
        if (scan_issue) begin
          mem_re    = 1'b1;
          mem_raddr = slot_of(front_q, idx_q);
          idx_d     = idx_q + CW'(1);
          pend_d    = 1'b1;
        end
        // The compacting write always lands behind the read pointer.
        if (pend_q) begin
          if (rd_data == val_q) begin
            answer_d = answer_q + DATA_W'(1);
          end else if (op_q == OP_ERASE) begin
            mem_we    = 1'b1;
            mem_waddr = slot_of(front_q, kept_q);
            mem_wdata = rd_data;
            kept_d    = kept_q + CW'(1);
          end
        end
        if (scan_done && op_q == OP_ERASE) begin
          count_d = kept_q;
        end
      end
      S_FRONT_RD: begin
        mem_re    = 1'b1;
        mem_raddr = front_q;
      end
      S_END_RD: begin
        mem_re      = 1'b1;
        mem_raddr   = end_slot;
        front_val_d = rd_data;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      front_q <= '0;
      count_q <= '0;
      idx_q   <= '0;
      kept_q  <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      kept_q  <= kept_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    val_q       <= val_d;
    answer_q    <= answer_d;
    status_q    <= status_d;
    front_val_q <= front_val_d;
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign res_valid_o      = (state_q == S_DONE) && out_free_i;
  assign res_o.answer     = answer_q;
  assign res_o.status     = status_q;
  assign res_o.occupancy  = OCC_W'(count_q);
  assign res_o.front      = empty ? '0 : front_val_q;
  assign res_o.back       = empty ? '0 : rd_data;

endmodule

// ===== rtl/double_ended_queue_with_erase_top.sv =====
// Top level of the bounded deque with erase: sequencer plus output register.
//
//   channel  direction  handshake                 words
//   in       input      in_valid_i / in_stall_o   operation_i, item_value_i
//   out      output     out_valid_o / out_stall_i answer_value_o, status_o,
//                                                 occupancy_o, front_value_o,
//                                                 end_value_o
//
// A push or an unused code passes through exec, front read, end read and done; a
// non-empty pop adds a wait for its read data; count or erase walk the single read
// port of the entry RAM once per entry held, and front and end are reread after it.
// Reset clears pointers and control; the entry RAM is not cleared.
// The input stalls from accept until the result is loaded into the output
// register; the next word can be accepted while that result waits on a stall.
`include "double_ended_queue_with_erase_top_assert.svh"

module double_ended_queue_with_erase_top #(
  parameter int DEPTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [2:0]                        operation_i,
  input  logic signed [dqe_pkg::DATA_W-1:0] item_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [dqe_pkg::DATA_W-1:0] answer_value_o,
  output logic [1:0]                        status_o,
  output logic [dqe_pkg::OCC_W-1:0]         occupancy_o,
  output logic signed [dqe_pkg::DATA_W-1:0] front_value_o,
  output logic signed [dqe_pkg::DATA_W-1:0] end_value_o
);

  import dqe_pkg::*;

  logic  out_valid_q, out_valid_d;
  res_t  out_q;
  res_t  res;
  logic  res_valid;
  logic  out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  dqe_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .item_value_i(item_value_i),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign answer_value_o = out_q.answer;
  assign status_o       = out_q.status;
  assign occupancy_o    = out_q.occupancy;
  assign front_value_o  = out_q.front;
  assign end_value_o    = out_q.back;

  `DQE_ASSERT_NOW(a_no_overwrite, res_valid, !out_valid_q || !out_stall_i)
  `DQE_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  `DQE_ASSERT_NOW(a_full_occupancy, out_valid_q && out_q.status == ST_FULL,
                  out_q.occupancy == OCC_W'(DEPTH))
  `DQE_ASSERT_NOW(a_empty_pop, out_valid_q && out_q.status == ST_EMPTY,
                  out_q.occupancy == '0 && out_q.answer == '0)

endmodule
